// ===== design/hti_pkg.sv =====
package hti_pkg;

    localparam int unsigned HASH_W       = 32;
    localparam int unsigned INDEX_W      = 16;
    localparam int unsigned POS_W        = 10;
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned CFG_INDEX_W  = 8;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [HASH_W-1:0]  FNV_BASIS    = 32'd2166136261;
    localparam logic [INDEX_W-1:0] VOCAB_RESET  = 16'd20000;
    localparam logic [COUNT_W-1:0] MAXTOK_RESET = 11'd1000;
    localparam logic [COUNT_W-1:0] MAXTOK_CAP   = 11'd1024;

    localparam logic [CFG_INDEX_W-1:0] REG_VOCAB      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TOKENS = 8'd1;

    localparam int unsigned BITS_PER_CYCLE = 4;
    localparam int unsigned DIV_CYCLES     = HASH_W / BITS_PER_CYCLE;
    localparam int unsigned STEP_W         = $clog2(DIV_CYCLES);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } hti_in_t;

    typedef struct packed {
        logic               token_valid;
        logic [INDEX_W-1:0] token_index;
        logic [POS_W-1:0]   position;
        logic               end_of_sequence;
        logic [COUNT_W-1:0] token_count;
    } hti_out_t;

    typedef struct packed {
        logic               token_valid;
        logic [HASH_W-1:0]  hash;
        logic [POS_W-1:0]   position;
        logic               end_of_sequence;
        logic [COUNT_W-1:0] token_count;
    } hti_job_t;

    // multiply by 16777619 = 2^24 + 0x193, modulo 2^32
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        fnv_mul = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

// ===== design/hti_front.sv =====
module hti_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hti_pkg::COUNT_W-1:0]   limit,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hti_pkg::hti_in_t              s_data,
    output logic                          push,
    output hti_pkg::hti_job_t             push_job,
    input  logic                          queue_full
);
    import hti_pkg::*;

    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic               inside_reg, inside_next;
    logic [COUNT_W-1:0] words_reg, words_next;

    logic              accept;
    logic              space;
    logic              last;
    logic [HASH_W-1:0] hash_base;
    logic [HASH_W-1:0] hash_new;
    logic [HASH_W-1:0] word_hash;
    logic              word_done;
    logic              emit;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign space   = is_space(s_data.text_byte);
    assign last    = s_data.end_of_text;

    always_comb begin
        hash_base = inside_reg ? hash_reg : FNV_BASIS;
        hash_new  = fnv_mul(hash_base ^ {24'd0, s_data.text_byte});
        word_hash = space ? hash_reg : hash_new;
        word_done = (!space && last) || (space && inside_reg);
        emit      = word_done && (words_reg < limit);

        push                     = accept && (emit || last);
        push_job.token_valid     = emit;
        push_job.hash            = word_hash;
        push_job.position        = emit ? words_reg[POS_W-1:0] : '0;
        push_job.end_of_sequence = last;
        push_job.token_count     = emit ? words_reg + COUNT_W'(1) : words_reg;

        hash_next   = hash_reg;
        inside_next = inside_reg;
        words_next  = words_reg;
        if (accept) begin
            if (last) begin
                hash_next   = FNV_BASIS;
                inside_next = 1'b0;
                words_next  = '0;
            end else if (!space) begin
                hash_next   = hash_new;
                inside_next = 1'b1;
            end else begin
                hash_next   = FNV_BASIS;
                inside_next = 1'b0;
                if (emit) begin
                    words_next = words_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg   <= FNV_BASIS;
            inside_reg <= 1'b0;
            words_reg  <= '0;
        end else begin
            hash_reg   <= hash_next;
            inside_reg <= inside_next;
            words_reg  <= words_next;
        end
    end

endmodule

// ===== design/hti_queue.sv =====
module hti_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  hti_pkg::hti_job_t  push_job,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output hti_pkg::hti_job_t  pop_job
);
    import hti_pkg::*;

    hti_job_t            slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;

    assign full      = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_job   = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/hti_back.sv =====
module hti_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hti_pkg::INDEX_W-1:0]   modulus,
    input  logic                          job_valid,
    input  hti_pkg::hti_job_t             job,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hti_pkg::hti_out_t             m_data
);
    import hti_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    hti_out_t           out_reg, out_next;
    hti_job_t           meta_reg;
    logic [INDEX_W-1:0] rem_reg, rem_new;
    logic [HASH_W-1:0]  dvd_reg, dvd_new;

    logic               out_free;
    logic               last_step;
    logic [INDEX_W:0]   trial;
    logic [INDEX_W-1:0] r;
    logic [HASH_W-1:0]  d;

    assign out_free  = !out_valid_reg || m_ready;
    assign last_step = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // restoring remainder, several quotient bits per cycle
    always_comb begin
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++) begin
            trial = {r, d[HASH_W-1]};
            d     = d << 1;
            if (trial >= {1'b0, modulus}) begin
                trial = trial - {1'b0, modulus};
            end
            r = trial[INDEX_W-1:0];
        end
        rem_new = r;
        dvd_new = d;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        out_next   = out_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid && (job.token_valid || out_free)) begin
                    pop = 1'b1;
                    if (job.token_valid) begin
                        state_next = ST_DIV;
                        step_next  = '0;
                    end else begin
                        out_load                 = 1'b1;
                        out_next.token_valid     = 1'b0;
                        out_next.token_index     = '0;
                        out_next.position        = '0;
                        out_next.end_of_sequence = job.end_of_sequence;
                        out_next.token_count     = job.token_count;
                    end
                end
            end
            ST_DIV: begin
                step_next = step_reg + STEP_W'(1);
                if (last_step) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
                out_next.token_valid     = 1'b1;
                out_next.token_index     = rem_new + INDEX_W'(1);
                out_next.position        = meta_reg.position;
                out_next.end_of_sequence = meta_reg.end_of_sequence;
                out_next.token_count     = meta_reg.token_count;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                out_next.token_valid     = 1'b1;
                out_next.token_index     = rem_reg + INDEX_W'(1);
                out_next.position        = meta_reg.position;
                out_next.end_of_sequence = meta_reg.end_of_sequence;
                out_next.token_count     = meta_reg.token_count;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
        if (pop) begin
            meta_reg <= job;
            dvd_reg  <= job.hash;
            rem_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            dvd_reg <= dvd_new;
            rem_reg <= rem_new;
        end
    end

endmodule

// ===== design/hashed_token_indexer.sv =====
// Word tokenizer with 32-bit FNV-1a feature hashing. Text enters one byte per
// beat on s_*, end_of_text set on the final byte. Each finished word gives one
// m_* beat with its index (hash mod (vocabulary size - 1)) + 1, its position and
// the running count; the final byte always gives a beat with end_of_sequence set,
// merged with the last word when that word ends there. Words past max_tokens
// are dropped. The front takes one byte per cycle while its 4-entry queue has
// room; the back computes each index in a remainder unit that resolves 4 bits
// per cycle, and takes the next word from the queue only once the last index
// is loaded into the output register; a bare end mark needs no division.
// Registers on cfg_*: index 0 vocabulary size (reset 20000), index 1 max_tokens
// (reset 1000); write them only while the block is idle.
module hashed_token_indexer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  hti_pkg::hti_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hti_pkg::hti_out_t                 m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hti_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hti_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hti_pkg::*;

    logic [INDEX_W-1:0] vocab_reg;
    logic [COUNT_W-1:0] maxtok_reg;
    logic [INDEX_W-1:0] modulus;
    logic [COUNT_W-1:0] limit;

    logic     push;
    hti_job_t push_job;
    logic     queue_full;
    logic     pop;
    logic     pop_valid;
    hti_job_t pop_job;

    assign cfg_ready = 1'b1;
    assign modulus   = (vocab_reg < INDEX_W'(2)) ? INDEX_W'(1) : vocab_reg - INDEX_W'(1);
    assign limit     = (maxtok_reg > MAXTOK_CAP) ? MAXTOK_CAP : maxtok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vocab_reg  <= VOCAB_RESET;
            maxtok_reg <= MAXTOK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_VOCAB) begin
                vocab_reg <= cfg_data[INDEX_W-1:0];
            end else if (cfg_index == REG_MAX_TOKENS) begin
                maxtok_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    hti_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .limit      (limit),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    hti_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    hti_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .modulus   (modulus),
        .job_valid (pop_valid),
        .job       (pop_job),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/sv/hashed_token_indexer_tb.sv =====
module hashed_token_indexer_tb;
    import hti_pkg::*;

    localparam logic [HASH_W-1:0]      FNV_PRIME     = 32'd16777619;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED    = 8'd7;
    localparam int unsigned            SETTLE_CYCLES = 16;
    localparam int unsigned            HOLD_CYCLES   = 150;
    localparam int unsigned            STALL_LIMIT   = 2000;
    localparam int unsigned            DIR_ROWS      = 37;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  cfg_reg;
        logic [CFG_DATA_W-1:0]   cfg_val;
        hti_in_t                 beat;
        logic                    known;
        hti_out_t                result;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    hti_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    hti_out_t               m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // result typed into the directed table, travels with its beat
    logic                   known_valid;
    hti_out_t               known_result;

    // tokenizer state as predicted
    logic [INDEX_W-1:0]     vocab_reg  = VOCAB_RESET;
    logic [COUNT_W-1:0]     maxtok_reg = MAXTOK_RESET;
    logic [HASH_W-1:0]      word_hash  = FNV_BASIS;
    logic                   in_word    = 1'b0;
    logic [COUNT_W-1:0]     tokens_out = '0;

    hti_out_t               pending_results[$];
    int unsigned            mismatches   = 0;
    int unsigned            quiet_cycles = 0;
    int unsigned            gap_pct      = 15;
    int unsigned            stall_pct    = 15;
    bit                     hold_req     = 1'b0;

    dir_row_t               dir_table [DIR_ROWS];

    hashed_token_indexer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [7:0] random_blank();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? 8'h20 : 8'h09 + 8'(pick);
    endfunction

    function automatic void tokenize_byte(input hti_in_t beat, output logic produced,
                                          output hti_out_t res);
        logic [HASH_W-1:0]  modulus;
        logic [HASH_W-1:0]  index_full;
        logic [COUNT_W-1:0] limit;
        logic               word_done;
        logic               last;
        last      = beat.end_of_text;
        word_done = 1'b0;
        produced  = 1'b0;
        res       = '0;
        limit     = (maxtok_reg > MAXTOK_CAP) ? MAXTOK_CAP : maxtok_reg;
        modulus   = (vocab_reg < 16'd2) ? 32'd1 : 32'(vocab_reg) - 32'd1;
        if (!is_blank(beat.text_byte)) begin
            if (!in_word) begin
                word_hash = FNV_BASIS;
            end
            word_hash = (word_hash ^ 32'(beat.text_byte)) * FNV_PRIME;
            in_word   = 1'b1;
            word_done = last;
        end else if (in_word) begin
            word_done = 1'b1;
        end
        if (word_done) begin
            in_word = 1'b0;
            if (tokens_out < limit) begin
                index_full          = word_hash % modulus + 32'd1;
                res.token_valid     = 1'b1;
                res.token_index     = index_full[INDEX_W-1:0];
                res.position        = tokens_out[POS_W-1:0];
                tokens_out          = tokens_out + COUNT_W'(1);
                res.end_of_sequence = last;
                res.token_count     = tokens_out;
                produced            = 1'b1;
            end
            word_hash = FNV_BASIS;
        end
        if (last) begin
            if (!produced) begin
                res.end_of_sequence = 1'b1;
                res.token_count     = tokens_out;
                produced            = 1'b1;
            end
            word_hash  = FNV_BASIS;
            in_word    = 1'b0;
            tokens_out = '0;
        end
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.cfg_reg = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic dir_row_t beat_row(input logic [7:0] b, input logic eot);
        dir_row_t r;
        r                  = '0;
        r.kind             = ROW_BEAT;
        r.beat.text_byte   = b;
        r.beat.end_of_text = eot;
        return r;
    endfunction

    function automatic dir_row_t known_row(input logic [7:0] b, input logic eot,
                                           input logic tv, input logic [INDEX_W-1:0] idx,
                                           input logic [POS_W-1:0] pos, input logic eos,
                                           input logic [COUNT_W-1:0] cnt);
        dir_row_t r;
        r                        = beat_row(b, eot);
        r.known                  = 1'b1;
        r.result.token_valid     = tv;
        r.result.token_index     = idx;
        r.result.position        = pos;
        r.result.end_of_sequence = eos;
        r.result.token_count     = cnt;
        return r;
    endfunction

    // scoreboard: predict on every accepted byte, check every accepted result
    always @(posedge aclk) begin : scoreboard
        hti_out_t predicted;
        hti_out_t want;
        logic     produced;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VOCAB: vocab_reg = cfg_data;
                    REG_MAX_TOKENS: maxtok_reg = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                tokenize_byte(s_data, produced, predicted);
                if (known_valid) begin
                    produced  = 1'b1;
                    predicted = known_result;
                end
                if (produced) begin
                    pending_results.insert(pending_results.size(), predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing pending, expected none, actual %h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("token_valid", 32'(want.token_valid),
                                  32'(m_data.token_valid));
                    compare_field("token_index", 32'(want.token_index),
                                  32'(m_data.token_index));
                    compare_field("position", 32'(want.position), 32'(m_data.position));
                    compare_field("end_of_sequence", 32'(want.end_of_sequence),
                                  32'(m_data.end_of_sequence));
                    compare_field("token_count", 32'(want.token_count),
                                  32'(m_data.token_count));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if ($urandom_range(1, 100) <= stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_beat(input hti_in_t beat, input logic known, input hti_out_t res);
        if ($urandom_range(1, 100) <= gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data       <= beat;
        known_valid  <= known;
        known_result <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain(input int unsigned settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] vocab,
                                input logic [CFG_DATA_W-1:0] maxtok, input logic poke_unused);
        drain(SETTLE_CYCLES);
        write_reg(REG_VOCAB, vocab);
        write_reg(REG_MAX_TOKENS, maxtok);
        if (poke_unused) begin
            write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text(input int unsigned words, input int unsigned max_len,
                             input int unsigned max_sep, input logic noise);
        logic [7:0]  text_q[$];
        logic [7:0]  b;
        hti_in_t     beat;
        int unsigned w;
        int unsigned k;
        int unsigned n;
        if (noise) begin
            n = $urandom_range(1, words * max_len + 1);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    text_q.insert(text_q.size(), random_blank());
                end else begin
                    text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                end
            end
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), random_blank());
            end
            for (w = 0; w < words; w++) begin
                n = $urandom_range(1, max_len);
                for (k = 0; k < n; k++) begin
                    do b = 8'($urandom_range(0, 255)); while (is_blank(b));
                    text_q.insert(text_q.size(), b);
                end
                // trailing blank on the last word is optional
                if (w + 1 < words || $urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, max_sep)) begin
                        text_q.insert(text_q.size(), random_blank());
                    end
                end
            end
        end
        if (text_q.size() == 0) begin
            text_q.insert(0, random_blank());
        end
        foreach (text_q[i]) begin
            beat.text_byte   = text_q[i];
            beat.end_of_text = (i == text_q.size() - 1);
            send_beat(beat, 1'b0, '0);
        end
    endtask

    initial begin
        int unsigned t;
        int unsigned r;
        logic        cfg_open;
        cfg_open     = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        known_valid  <= 1'b0;
        known_result <= '0;

        dir_table = '{
            // reset values
            known_row(8'h20, 1'b1, 1'b0, 16'd0, 10'd0, 1'b1, 11'd0),
            beat_row(8'h08, 1'b0),
            beat_row(8'h0E, 1'b0),
            beat_row(8'h09, 1'b0),
            beat_row(8'h00, 1'b0),
            beat_row(8'h0D, 1'b0),
            beat_row(8'hFF, 1'b1),
            beat_row(8'h0A, 1'b0),
            beat_row(8'h0B, 1'b0),
            beat_row(8'h1F, 1'b0),
            beat_row(8'h21, 1'b0),
            beat_row(8'h0C, 1'b1),
            // zero limit, vocab below two
            cfg_row(REG_VOCAB, 16'd0),
            cfg_row(REG_MAX_TOKENS, 16'd0),
            beat_row(8'h78, 1'b0),
            beat_row(8'h20, 1'b0),
            known_row(8'h79, 1'b1, 1'b0, 16'd0, 10'd0, 1'b1, 11'd0),
            // every index is one, later words dropped
            cfg_row(REG_VOCAB, 16'd1),
            cfg_row(REG_MAX_TOKENS, 16'd2),
            beat_row(8'h61, 1'b0),
            known_row(8'h20, 1'b0, 1'b1, 16'd1, 10'd0, 1'b0, 11'd1),
            beat_row(8'h62, 1'b0),
            known_row(8'h09, 1'b0, 1'b1, 16'd1, 10'd1, 1'b0, 11'd2),
            beat_row(8'h63, 1'b0),
            beat_row(8'h20, 1'b0),
            known_row(8'h64, 1'b1, 1'b0, 16'd0, 10'd0, 1'b1, 11'd2),
            // widest vocab, limit past the cap, write to an unmapped index
            cfg_row(REG_VOCAB, 16'hFFFF),
            cfg_row(REG_MAX_TOKENS, 16'd2047),
            cfg_row(REG_UNUSED, 16'hFFFF),
            beat_row(8'h65, 1'b1),
            beat_row(8'h80, 1'b0),
            beat_row(8'h20, 1'b1),
            // smallest real vocab, single word limit
            cfg_row(REG_VOCAB, 16'd2),
            cfg_row(REG_MAX_TOKENS, 16'd1),
            beat_row(8'h7A, 1'b0),
            known_row(8'h20, 1'b0, 1'b1, 16'd1, 10'd0, 1'b0, 11'd1),
            known_row(8'h71, 1'b1, 1'b0, 16'd0, 10'd0, 1'b1, 11'd1)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    drain(SETTLE_CYCLES);
                end
                write_reg(dir_table[r].cfg_reg, dir_table[r].cfg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                end
                cfg_open = 1'b0;
                send_beat(dir_table[r].beat, dir_table[r].known, dir_table[r].result);
            end
        end

        // long receiver hold while short words keep coming
        apply_config(16'hFFFF, 16'd1024, 1'b0);
        hold_req = 1'b1;
        send_text(24, 2, 1, 1'b0);
        for (t = 0; t < 12; t++) begin
            send_text($urandom_range(1, 6), 6, 2, $urandom_range(0, 7) == 0);
        end

        // tiny vocab and limit, many dropped words, receiver always ready
        stall_pct = 0;
        apply_config(16'($urandom_range(2, 20)), 16'($urandom_range(1, 6)), 1'b1);
        for (t = 0; t < 15; t++) begin
            send_text($urandom_range(1, 8), 3, 2, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0) begin
                drain(0);
            end
        end

        // limit past the cap, long texts
        stall_pct = 15;
        apply_config(16'($urandom_range(2, 65535)), 16'd2047, 1'b0);
        for (t = 0; t < 6; t++) begin
            send_text($urandom_range(20, 60), 4, 2, 1'b0);
        end

        // everything random, upper data bits set on the limit
        apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
        for (t = 0; t < 12; t++) begin
            send_text($urandom_range(1, 6), 6, 3, $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 5) == 0) begin
                drain(0);
            end
        end

        // no idling on either side
        gap_pct   = 0;
        stall_pct = 0;
        apply_config(VOCAB_RESET, 16'(MAXTOK_RESET), 1'b0);
        for (t = 0; t < 10; t++) begin
            send_text($urandom_range(1, 6), 6, 2, $urandom_range(0, 7) == 0);
        end

        drain(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
